// File: hdl/jump_preserving_moving_average_core_macros.svh
// Assertion macros shared by the jump-preserving moving average RTL.
`ifndef JUMP_PRESERVING_MOVING_AVERAGE_CORE_MACROS_SVH
`define JUMP_PRESERVING_MOVING_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define JPMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define JPMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/jpma_pkg.sv
// Types and fixed constants of the jump-preserving moving average.
`default_nettype none

package jpma_pkg;

  // width of the jump threshold register
  localparam int THR_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_DIV,
    ST_RAWRD,
    ST_RAWCAP,
    ST_EMIT
  } jpma_state_t;

endpackage

`default_nettype wire

// File: hdl/jpma_div.sv
// Division by a constant odd divisor: reciprocal multiply, one 16-bit dividend chunk per cycle.
`default_nettype none

module jpma_div #(
  parameter int DW      = 20,
  parameter int DIVISOR = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  // floor(x / DIVISOR) == (x * MUL) >> SH for every x below 2**DW
  localparam int LW  = $clog2(DIVISOR);
  localparam int SH  = DW + LW;
  localparam int MW  = DW + 1;
  localparam longint unsigned MUL =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] MUL_C = MW'(MUL);
  localparam int CH  = 16;
  localparam int NCH = (DW + CH - 1) / CH;
  localparam int XW  = NCH * CH;
  localparam int PW  = XW + MW;
  localparam int CW  = $clog2(NCH + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [XW-1:0]    x_r;
  logic [PW-1:0]    acc_r;

  logic [CH+MW-1:0] prod;
  logic [PW-1:0]    acc_nxt;

  assign prod    = (CH+MW)'(x_r[XW-1 -: CH]) * (CH+MW)'(MUL_C);
  assign acc_nxt = (acc_r << CH) + PW'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NCH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // chunks leave from the top, Horner style: acc = acc * 2**CH + chunk * MUL
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= XW'(dividend);
      acc_r <= '0;
    end else if (busy_r) begin
      x_r   <= x_r << CH;
      acc_r <= acc_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = DW'(acc_r[PW-1:SH]);

endmodule

`default_nettype wire

// File: hdl/jump_preserving_moving_average_core.sv
// Top level: jump-preserving moving average over a memory-held sample window.
// Filtered item: accept, window walk over SPAN samples, check, reciprocal multiply, emit;
//   a jump in the window skips the multiply.
// Raw item before the window fills: read, capture, emit; a flush repeats them per held sample.
// Rate is set by the single read port of the window memory; output stalls hold emit.
// Reset (sync, active low) clears control, count and threshold; memory is not cleared.
`default_nettype none

`include "jump_preserving_moving_average_core_macros.svh"

module jump_preserving_moving_average_core #(
  parameter int WINDOW      = 11,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [jpma_pkg::THR_BITS-1:0]     cfg_jump_threshold,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  wire logic                              in_end_of_record,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_value,
  output logic                                   out_was_averaged,
  output logic                                   out_final_res
);

  // An even WINDOW behaves as WINDOW-1: only SPAN entries are ever read.
  localparam int SB   = SAMPLE_BITS;
  localparam int HALF = (WINDOW - 1) / 2;
  localparam int SPAN = 2 * HALF + 1;
  localparam int AW   = $clog2(SPAN);       // memory index / sample age
  localparam int KW   = $clog2(SPAN + 1);   // counts up to SPAN
  localparam int SUMW = SB + AW;            // signed window sum
  localparam int TW   = jpma_pkg::THR_BITS;
  localparam int CMPW = (SB + 1 > TW) ? SB + 1 : TW;

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  jpma_pkg::jpma_state_t state_r, state_nxt;

  logic [TW-1:0] thr_r;
  logic [KW-1:0] seen_r;     // samples of current record held, saturates at SPAN
  logic [AW-1:0] newest_r;   // memory slot of the newest sample
  logic          end_r;      // current transaction closes its record
  logic [AW-1:0] age_r;      // age of the sample whose result is pending
  logic [KW-1:0] k_r;        // window walk step

  // window datapath
  logic signed [SUMW-1:0] sum_r;
  logic signed [SB-1:0]   min_r;
  logic signed [SB-1:0]   max_r;
  logic [SB-1:0]          centre_r;
  logic [SB-1:0]          res_val_r;
  logic                   res_avg_r;

  // output register
  logic          out_valid_r;
  logic [SB-1:0] out_value_r;
  logic          out_avg_r;
  logic          out_fin_r;

  // window memory: one write port (on accept), one registered read port
  logic [SB-1:0] win_mem [SPAN];
  logic [SB-1:0] rdata_r;

  // ---------------------------------------------------------------
  // Input side decode
  // ---------------------------------------------------------------
  logic          in_acc;
  logic [KW-1:0] have;
  logic [KW-1:0] have_m1;
  logic [AW-1:0] age_init;
  logic [AW-1:0] wr_addr;

  assign in_stall = (state_r != jpma_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign have     = (seen_r == KW'(SPAN)) ? seen_r : seen_r + 1'b1;
  assign have_m1  = have - 1'b1;
  // first result is the sample HALF back, or the oldest held on a short flush
  assign age_init = (have_m1 > KW'(HALF)) ? AW'(HALF) : have_m1[AW-1:0];
  assign wr_addr  = (newest_r == AW'(SPAN - 1)) ? '0 : newest_r + 1'b1;

  // ---------------------------------------------------------------
  // Read address: slot of a given age, modulo SPAN
  // ---------------------------------------------------------------
  logic          rd_en;
  logic [AW-1:0] rd_age;
  logic [AW:0]   addr_dn;
  logic [AW:0]   addr_wr;
  logic [AW-1:0] rd_addr;

  assign addr_dn = {1'b0, newest_r} - {1'b0, rd_age};
  assign addr_wr = {1'b0, newest_r} + (AW+1)'(SPAN) - {1'b0, rd_age};
  assign rd_addr = (newest_r >= rd_age) ? addr_dn[AW-1:0] : addr_wr[AW-1:0];

  // ---------------------------------------------------------------
  // Spread check and divider hookup
  // ---------------------------------------------------------------
  logic [SB:0]            spread;
  logic                   smooth;
  logic [SUMW-1:0]        sum_mag;
  logic [SUMW-1:0]        dividend;
  logic                   div_start;
  logic                   div_done;
  logic [SUMW-1:0]        quotient;
  logic [SB-1:0]          q_lo;
  logic [SB-1:0]          q_signed;
  logic signed [SB-1:0]   rdata_s;
  logic signed [SUMW-1:0] rdata_ext;

  // max >= min once the walk is done, so the difference is non-negative
  assign spread   = {max_r[SB-1], max_r} - {min_r[SB-1], min_r};
  assign smooth   = (CMPW'(spread) <= CMPW'(thr_r));
  assign sum_mag  = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  // adding HALF before dividing rounds to nearest (SPAN odd, no ties)
  assign dividend = sum_mag + SUMW'(HALF);
  assign q_lo     = quotient[SB-1:0];
  assign q_signed = sum_r[SUMW-1] ? (~q_lo + 1'b1) : q_lo;

  assign rdata_s   = rdata_r;
  assign rdata_ext = SUMW'(rdata_s);

  jpma_div #(
    .DW      (SUMW),
    .DIVISOR (SPAN)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jpma_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (have == KW'(SPAN)) begin
            state_nxt = jpma_pkg::ST_WALK;
          end else if (in_end_of_record || (have >= KW'(HALF + 1))) begin
            state_nxt = jpma_pkg::ST_RAWRD;
          end
        end
      end
      jpma_pkg::ST_WALK: begin
        if (k_r == KW'(SPAN)) begin
          state_nxt = jpma_pkg::ST_CHECK;
        end
      end
      jpma_pkg::ST_CHECK: begin
        state_nxt = smooth ? jpma_pkg::ST_DIV : jpma_pkg::ST_EMIT;
      end
      jpma_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = jpma_pkg::ST_EMIT;
        end
      end
      jpma_pkg::ST_RAWRD: begin
        state_nxt = jpma_pkg::ST_RAWCAP;
      end
      jpma_pkg::ST_RAWCAP: begin
        state_nxt = jpma_pkg::ST_EMIT;
      end
      jpma_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = (end_r && (age_r != '0)) ? jpma_pkg::ST_RAWRD : jpma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jpma_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------
  logic walk_acc;   // rdata_r holds window sample of age k_r-1
  logic load_out;

  always_comb begin
    rd_en     = 1'b0;
    rd_age    = age_r;
    walk_acc  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      jpma_pkg::ST_WALK: begin
        rd_en    = (k_r < KW'(SPAN));
        rd_age   = k_r[AW-1:0];
        walk_acc = (k_r != '0);
      end
      jpma_pkg::ST_CHECK: begin
        div_start = smooth;
      end
      jpma_pkg::ST_RAWRD: begin
        rd_en = 1'b1;
      end
      jpma_pkg::ST_EMIT: begin
        load_out = out_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jpma_pkg::ST_IDLE;
      thr_r       <= '0;
      seen_r      <= '0;
      newest_r    <= AW'(SPAN - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_jump_threshold;
      end
      if (in_acc) begin
        newest_r <= wr_addr;
        seen_r   <= in_end_of_record ? '0 : have;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memory: write the accepted sample, registered read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_mem[wr_addr] <= in_sample;
    end
    if (rd_en) begin
      rdata_r <= win_mem[rd_addr];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      end_r <= in_end_of_record;
      age_r <= age_init;
      k_r   <= '0;
    end
    if (state_r == jpma_pkg::ST_WALK) begin
      k_r <= k_r + 1'b1;
    end
    if (walk_acc) begin
      if (k_r == KW'(1)) begin
        sum_r <= rdata_ext;
        min_r <= rdata_s;
        max_r <= rdata_s;
      end else begin
        sum_r <= sum_r + rdata_ext;
        if (rdata_s < min_r) begin
          min_r <= rdata_s;
        end
        if (rdata_s > max_r) begin
          max_r <= rdata_s;
        end
      end
      if (k_r == KW'(HALF + 1)) begin
        centre_r <= rdata_r;
      end
    end
    // a jump in the window: centre passes raw
    if ((state_r == jpma_pkg::ST_CHECK) && !smooth) begin
      res_val_r <= centre_r;
      res_avg_r <= 1'b0;
    end
    if ((state_r == jpma_pkg::ST_DIV) && div_done) begin
      res_val_r <= q_signed;
      res_avg_r <= 1'b1;
    end
    if (state_r == jpma_pkg::ST_RAWCAP) begin
      res_val_r <= rdata_r;
      res_avg_r <= 1'b0;
    end
    if (load_out) begin
      out_value_r <= res_val_r;
      out_avg_r   <= res_avg_r;
      out_fin_r   <= end_r && (age_r == '0);
      if (end_r && (age_r != '0)) begin
        age_r <= age_r - 1'b1;
      end
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_was_averaged = out_avg_r;
  assign out_final_res    = out_fin_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `JPMA_ASSERT_IMP(a_seen_sat, 1'b1, seen_r <= KW'(SPAN), "sample count beyond window span")
  `JPMA_ASSERT_NXT(a_end_clears, in_acc && in_end_of_record, seen_r == '0, "end mark did not clear count")
  `JPMA_ASSERT_IMP(a_walk_full, state_r == jpma_pkg::ST_WALK, (end_r && seen_r == '0) || (!end_r && seen_r == KW'(SPAN)), "window walk without full window")
  `JPMA_ASSERT_IMP(a_div_state, div_done, state_r == jpma_pkg::ST_DIV, "divider finished outside divide state")

endmodule

`default_nettype wire
